@@ rtl/assert_macros.svh @@
// Assertion macros shared by the interrupt vector pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk and disabled while rst_n is low.
`define IVP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define IVP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IVP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ivp_pkg.sv @@
// Shared types and constants of the interrupt vector pool.
`default_nettype none
package ivp_pkg;

    localparam int ACTION_W  = 3;
    localparam int VECTOR_W  = 8;
    localparam int HANDLER_W = 8;
    localparam int COUNT_W   = 7;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 24;

    localparam logic [ACTION_W-1:0] ACT_ALLOC    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REGISTER = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UNREG    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DISPATCH = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // Latch the request and read the handler table.
        logic commit;   // Apply the action and load the result register.
    } ivp_cmd_t;

endpackage
`default_nettype wire

@@ rtl/ivp_ctrl.sv @@
// Controller of the interrupt vector pool: request sequencing and output handshake.
`default_nettype none
`include "assert_macros.svh"
module ivp_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output ivp_pkg::ivp_cmd_t    cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        s_tready    = (state_reg == S_IDLE);
        cmd.capture = s_tvalid && (state_reg == S_IDLE);
        cmd.commit  = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `IVP_ASSERT_IMPL(a_commit_safe, cmd.commit, (state_reg == S_EXEC) && (!out_valid_reg || m_tready), "commit while result register is blocked")
    `IVP_ASSERT_NEXT(a_capture_to_exec, cmd.capture, state_reg == S_EXEC, "accepted request did not start execution")

endmodule
`default_nettype wire

@@ rtl/ivp_dp.sv @@
// Datapath of the interrupt vector pool: allocation bitmap, handler table and result register.
`default_nettype none
`include "assert_macros.svh"
module ivp_dp
#(
    parameter int VECTOR_BASE     = 96,
    parameter int VECTOR_COUNT    = 64,
    parameter int RESERVED_VECTOR = 128
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ivp_pkg::ivp_cmd_t           cmd,
    input  wire logic [ivp_pkg::IN_W-1:0]    s_tdata,
    output logic [ivp_pkg::OUT_W-1:0]        m_tdata
);

    localparam int SLOT_W     = (VECTOR_COUNT > 1) ? $clog2(VECTOR_COUNT) : 1;
    localparam int SLOT_LIMIT = ((VECTOR_BASE + VECTOR_COUNT) > 256) ?
                                (256 - VECTOR_BASE) : VECTOR_COUNT;
    localparam int RES_V      = RESERVED_VECTOR % 256;
    localparam bit RES_IN     = (RES_V >= VECTOR_BASE) && ((RES_V - VECTOR_BASE) < SLOT_LIMIT);
    localparam int RES_SLOT   = RES_IN ? (RES_V - VECTOR_BASE) : 0;
    localparam logic [VECTOR_COUNT-1:0] RESET_MARKS =
        RES_IN ? (VECTOR_COUNT'(1) << RES_SLOT) : '0;
    localparam logic [ivp_pkg::COUNT_W-1:0] RESET_COUNT = ivp_pkg::COUNT_W'(RES_IN);
    localparam logic [8:0] BASE9  = 9'(VECTOR_BASE);
    localparam logic [8:0] LIMIT9 = 9'(SLOT_LIMIT);

    // Input fields.
    logic [ivp_pkg::ACTION_W-1:0]  in_action;
    logic [ivp_pkg::VECTOR_W-1:0]  in_vector;
    logic [ivp_pkg::HANDLER_W-1:0] in_handler;
    logic [8:0]                    in_diff;
    logic                          in_range;

    // Request registers.
    logic [ivp_pkg::ACTION_W-1:0]  action_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic                          in_range_reg;
    logic [ivp_pkg::HANDLER_W-1:0] hid_reg;
    logic [ivp_pkg::HANDLER_W-1:0] rd_data_reg;

    // Pool state.
    logic [VECTOR_COUNT-1:0]        marks_reg;
    logic [VECTOR_COUNT-1:0]        marks_next;
    logic [VECTOR_COUNT-1:0]        hvalid_reg;
    logic [VECTOR_COUNT-1:0]        hvalid_next;
    logic [ivp_pkg::COUNT_W-1:0]    count_reg;
    logic [ivp_pkg::COUNT_W-1:0]    count_next;
    logic [ivp_pkg::HANDLER_W-1:0]  handler_mem [VECTOR_COUNT];
    logic                           mem_we;

    // First-fit search.
    logic [VECTOR_COUNT-1:0] limit_mask;
    logic [VECTOR_COUNT-1:0] free_bits;
    logic [VECTOR_COUNT-1:0] lowest_free;
    logic                    any_free;
    logic [SLOT_W-1:0]       alloc_idx;

    // Result.
    logic                          status_next;
    logic [ivp_pkg::VECTOR_W-1:0]  granted_next;
    logic [ivp_pkg::HANDLER_W-1:0] bound_next;
    logic                          status_reg;
    logic [ivp_pkg::VECTOR_W-1:0]  granted_reg;
    logic [ivp_pkg::HANDLER_W-1:0] bound_reg;
    logic [ivp_pkg::COUNT_W-1:0]   used_reg;

    assign in_action  = s_tdata[2:0];
    assign in_vector  = s_tdata[10:3];
    assign in_handler = s_tdata[18:11];
    assign in_diff    = {1'b0, in_vector} - BASE9;
    assign in_range   = ({1'b0, in_vector} >= BASE9) && (in_diff < LIMIT9);

    always_comb
    begin
        for (int i = 0; i < VECTOR_COUNT; i++)
        begin
            limit_mask[i] = (i < SLOT_LIMIT);
        end
        free_bits   = ~marks_reg & limit_mask;
        lowest_free = free_bits & (~free_bits + VECTOR_COUNT'(1));
        any_free    = |free_bits;
        alloc_idx   = '0;
        for (int b = 0; b < SLOT_W; b++)
        begin
            for (int i = 0; i < VECTOR_COUNT; i++)
            begin
                if (i[b])
                begin
                    alloc_idx[b] = alloc_idx[b] | lowest_free[i];
                end
            end
        end
    end

    always_comb
    begin
        marks_next   = marks_reg;
        hvalid_next  = hvalid_reg;
        count_next   = count_reg;
        mem_we       = 1'b0;
        status_next  = ivp_pkg::STATUS_FAIL;
        granted_next = '0;
        bound_next   = '0;
        case (action_reg)
            ivp_pkg::ACT_ALLOC:
            begin
                if (any_free)
                begin
                    marks_next   = marks_reg | lowest_free;
                    count_next   = count_reg + ivp_pkg::COUNT_W'(1);
                    granted_next = 8'(BASE9 + 9'(alloc_idx));
                    status_next  = ivp_pkg::STATUS_OK;
                end
            end
            ivp_pkg::ACT_FREE:
            begin
                if (in_range_reg)
                begin
                    if (marks_reg[slot_reg])
                    begin
                        count_next = count_reg - ivp_pkg::COUNT_W'(1);
                    end
                    marks_next[slot_reg]  = 1'b0;
                    hvalid_next[slot_reg] = 1'b0;
                    status_next           = ivp_pkg::STATUS_OK;
                end
            end
            ivp_pkg::ACT_REGISTER:
            begin
                if (in_range_reg && (hid_reg != '0) && !hvalid_reg[slot_reg])
                begin
                    hvalid_next[slot_reg] = 1'b1;
                    mem_we                = 1'b1;
                    status_next           = ivp_pkg::STATUS_OK;
                end
            end
            ivp_pkg::ACT_UNREG:
            begin
                if (in_range_reg)
                begin
                    hvalid_next[slot_reg] = 1'b0;
                    status_next           = ivp_pkg::STATUS_OK;
                end
            end
            ivp_pkg::ACT_DISPATCH:
            begin
                if (in_range_reg)
                begin
                    bound_next  = hvalid_reg[slot_reg] ? rd_data_reg : '0;
                    status_next = ivp_pkg::STATUS_OK;
                end
            end
            default:
            begin
                status_next = ivp_pkg::STATUS_FAIL;
            end
        endcase
    end

    // Pool state; the handler table entries are qualified by hvalid_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg  <= RESET_MARKS;
            hvalid_reg <= '0;
            count_reg  <= RESET_COUNT;
        end
        else if (cmd.commit)
        begin
            marks_reg  <= marks_next;
            hvalid_reg <= hvalid_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= in_action;
            slot_reg     <= in_diff[SLOT_W-1:0];
            in_range_reg <= in_range;
            hid_reg      <= in_handler;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && in_range)
        begin
            rd_data_reg <= handler_mem[in_diff[SLOT_W-1:0]];
        end
        if (cmd.commit && mem_we)
        begin
            handler_mem[slot_reg] <= hid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            bound_reg   <= bound_next;
            used_reg    <= count_next;
        end
    end

    assign m_tdata = {used_reg, bound_reg, granted_reg, status_reg};

    `IVP_ASSERT(a_count_matches, count_reg == ivp_pkg::COUNT_W'($countones(marks_reg)), "in-use count disagrees with bitmap")
    `IVP_ASSERT(a_marks_in_window, (marks_reg & ~limit_mask) == '0, "mark set outside the vector window")

endmodule
`default_nettype wire

@@ rtl/interrupt_vector_pool.sv @@
// Top level of the interrupt vector pool: first-fit vector allocator with handler binding.
//
// Channel  Dir  Bits  Contents (lowest bit first)
// s_axis   in   24    action[2:0], vector[10:3], handler_id[18:11], zero pad
// m_axis   out  24    status[0], granted_vector[8:1], bound_handler[16:9], used_count[23:17]
//
// Each request is latched at its accepting edge, which also reads the handler
// table; the commit edge in S_EXEC then applies the action to the bitmap and
// the table and loads the result register. The first-fit search is a single
// lowest-set-bit pick over the allocation bitmap, used at that commit edge.
// Reset (rst_n low, asynchronous) empties the pool, clears all handlers and
// marks the syscall vector as allocated when it lies inside the window.
// A new request is taken while a result waits; if that result is still not
// taken when the next one is ready, the block holds until m_tready rises.
`default_nettype none
module interrupt_vector_pool
#(
    parameter int VECTOR_BASE     = 96,
    parameter int VECTOR_COUNT    = 64,
    parameter int RESERVED_VECTOR = 128
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // action, vector, handler_id, zero pad
    input  wire logic [ivp_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // status, granted_vector, bound_handler, used_count
    output logic [ivp_pkg::OUT_W-1:0]      m_tdata
);

    // Commands from the sequencing controller into the datapath.
    ivp_pkg::ivp_cmd_t cmd;

    // The controller owns both handshakes; the datapath holds all pool state.
    ivp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Bitmap, handler table, in-use counter and result register.
    ivp_dp
    #(
        .VECTOR_BASE     (VECTOR_BASE),
        .VECTOR_COUNT    (VECTOR_COUNT),
        .RESERVED_VECTOR (RESERVED_VECTOR)
    )
    u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire
